FILE: hw/rtl/sgd_pkg.sv
package sgd_pkg;

  // One coded bit travelling between the stages, with its valid flag
  typedef struct packed {
    logic valid;
    logic code_bit;
  } beat_t;

  // Entries of the bit queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Register map: word index taken from paddr[2]
  localparam int unsigned PaddrW = 3;
  localparam logic RegDivisor    = 1'b0;
  localparam logic RegSignMode   = 1'b1;

endpackage

FILE: hw/rtl/sgd_front.sv
module sgd_front
  import sgd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic  code_bit_i,
  output beat_t push_o,
  input  logic  queue_full_i
);

  logic valid_q, valid_d;
  logic bit_q;
  logic accept;
  logic pushed;

  // Hold the beat only while the queue refuses it
  assign pushed     = valid_q && !queue_full_i;
  assign in_stall_o = valid_q && queue_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (pushed) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the coded bit on each accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bit_q <= code_bit_i;
    end
  end

  assign push_o.valid    = pushed;
  assign push_o.code_bit = bit_q;

endmodule

FILE: hw/rtl/sgd_queue.sv
module sgd_queue
  import sgd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  beat_t push_i,
  output logic  full_o,
  output beat_t head_o,
  input  logic  pop_i
);

  localparam int unsigned CountW = $clog2(QueueDepth + 1);

  logic                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0]    count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (count_q == CountW'(QueueDepth));
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && (count_q != '0);

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed bit
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.code_bit;
    end
  end

  assign head_o.valid    = (count_q != '0);
  assign head_o.code_bit = mem_q[rd_ptr_q];

endmodule

FILE: hw/rtl/sgd_back.sv
module sgd_back
  import sgd_pkg::*;
#(
  parameter int unsigned DIVISOR_WIDTH = 16,
  parameter int unsigned VALUE_WIDTH   = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [DIVISOR_WIDTH-1:0] divisor_i,
  input  logic                     sign_mode_i,
  input  beat_t                    head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [VALUE_WIDTH-1:0]   decoded_value_o,
  output logic                     overflow_o
);

  localparam int unsigned DW = DIVISOR_WIDTH;
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned BW = $clog2(DW + 1);
  localparam int unsigned RW = DW + 1;
  localparam int unsigned MW = VW - 1;
  localparam int unsigned SW = ((MW > RW) ? MW : RW) + 1;

  localparam logic [1:0] PhUnary = 2'd0;
  localparam logic [1:0] PhRem   = 2'd1;
  localparam logic [1:0] PhExtra = 2'd2;
  localparam logic [1:0] PhSign  = 2'd3;

  localparam logic [MW-1:0] MagMax = {MW{1'b1}};

  logic [1:0]    phase_q, phase_d;
  logic [MW-1:0] mag_q, mag_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [BW-1:0] left_q, left_d;
  logic          sat_q, sat_d;

  logic                out_valid_q, out_valid_d;
  logic [VW-1:0]       value_q, value_d;
  logic                ovf_q, ovf_d;

  logic          advance;
  logic          cbit;
  logic [DW-1:0] m_eff;
  logic [BW-1:0] b_len;
  logic [RW-1:0] u_off;
  logic          m_is_one;
  logic [RW-1:0] r_shift;
  logic [RW-1:0] r_extra;
  logic [BW-1:0] left_dec;
  logic [1:0]    phase_c;
  logic [RW-1:0] rem_c;
  logic [BW-1:0] left_c;
  logic          add_m;
  logic          fin;
  logic [RW-1:0] fin_r;
  logic [SW-1:0] addend;
  logic [SW-1:0] sum;
  logic          sat_now;
  logic [MW-1:0] mag_new;
  logic          sat_new;
  logic [VW-1:0] half;
  logic [VW-1:0] mag_ext;
  logic          emit;

  assign advance = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o   = advance;
  assign cbit    = head_i.code_bit;

  // Effective divisor, code length b = ceil(log2 m) and offset u = 2^b - m
  always_comb begin
    m_eff = (divisor_i == '0) ? DW'(1) : divisor_i;
    b_len = '0;
    for (int k = 0; k < DW; k++) begin
      if ((RW'(1) << k) < RW'(m_eff)) begin
        b_len = BW'(k + 1);
      end
    end
    u_off    = (RW'(1) << b_len) - RW'(m_eff);
    m_is_one = (m_eff == DW'(1));
  end

  // Shift in the bit, and the offset-corrected remainder for the extra bit
  always_comb begin
    r_shift  = {rem_q[RW-2:0], cbit};
    r_extra  = (r_shift >= u_off) ? (r_shift - u_off) : '0;
    left_dec = (left_q != '0) ? (left_q - 1'b1) : '0;
  end

  // Classify the step: add m, enter a phase, or finish the magnitude
  always_comb begin
    phase_c = phase_q;
    rem_c   = rem_q;
    left_c  = left_q;
    add_m   = 1'b0;
    fin     = 1'b0;
    fin_r   = '0;
    unique case (phase_q)
      PhUnary: begin
        if (cbit) begin
          add_m = 1'b1;
        end else if (m_is_one) begin
          fin = 1'b1;
        end else begin
          rem_c  = '0;
          left_c = b_len - 1'b1;
          if (b_len == BW'(1)) begin
            if (u_off == '0) begin
              phase_c = PhExtra;
            end else begin
              fin = 1'b1;
            end
          end else begin
            phase_c = PhRem;
          end
        end
      end
      PhRem: begin
        rem_c  = r_shift;
        left_c = left_dec;
        if (left_dec == '0) begin
          if (r_shift >= u_off) begin
            phase_c = PhExtra;
          end else begin
            fin   = 1'b1;
            fin_r = r_shift;
          end
        end
      end
      PhExtra: begin
        rem_c = r_extra;
        fin   = 1'b1;
        fin_r = r_extra;
      end
      PhSign: begin
      end
      default: begin
      end
    endcase
  end

  // Saturating magnitude add
  assign addend  = add_m ? SW'(m_eff) : SW'(fin_r);
  assign sum     = SW'(mag_q) + addend;
  assign sat_now = (sum > SW'(MagMax));
  assign mag_new = sat_now ? MagMax : sum[MW-1:0];
  assign sat_new = sat_q | sat_now;

  assign half    = {2'b00, mag_new[MW-1:1]};
  assign mag_ext = {1'b0, mag_q};

  // Sign the magnitude and build the result beat
  always_comb begin
    phase_d = phase_c;
    rem_d   = rem_c;
    left_d  = left_c;
    mag_d   = mag_q;
    sat_d   = sat_q;
    emit    = 1'b0;
    value_d = value_q;
    ovf_d   = ovf_q;
    if (add_m) begin
      mag_d = mag_new;
      sat_d = sat_new;
    end
    if (fin) begin
      if (mag_new == '0) begin
        emit    = 1'b1;
        value_d = '0;
        ovf_d   = sat_new;
      end else if (!sign_mode_i) begin
        phase_d = PhSign;
        mag_d   = mag_new;
        sat_d   = sat_new;
      end else begin
        emit    = 1'b1;
        value_d = mag_new[0] ? ~half : half;
        ovf_d   = sat_new;
      end
    end
    if (phase_q == PhSign) begin
      emit    = 1'b1;
      value_d = cbit ? (VW'(0) - mag_ext) : mag_ext;
      ovf_d   = sat_q;
    end
    if (emit) begin
      phase_d = PhUnary;
      mag_d   = '0;
      sat_d   = 1'b0;
      rem_d   = '0;
      left_d  = '0;
    end
  end

  // Output beat valid: set on a result, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhUnary;
      mag_q       <= '0;
      rem_q       <= '0;
      left_q      <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q <= phase_d;
        mag_q   <= mag_d;
        rem_q   <= rem_d;
        left_q  <= left_d;
        sat_q   <= sat_d;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      value_q <= value_d;
      ovf_q   <= ovf_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign decoded_value_o = value_q;
  assign overflow_o      = ovf_q;

endmodule

FILE: hw/rtl/signed_golomb_decoder.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-------------------------------
// in       | input     | in_valid_i / in_stall_o | code_bit_i
// out      | output    | out_valid_o/ out_stall_i| decoded_value_o, overflow_o
// config   | APB       | psel/penable/pready     | paddr, pwdata, prdata
//
// One coded bit is taken per cycle while in_stall_o is low; a result beat is offered
// from the result register after the bit completing its codeword passes the front
// register and the bit queue. The decoder steps one bit per cycle while no result is
// stalled, through one saturating adder. A four-beat queue behind the front register
// takes up to five more bits while a result waits on out_stall_i.
// Reset clears control state and loads divisor 4, sign-magnitude mode.
module signed_golomb_decoder
  import sgd_pkg::*;
#(
  parameter int unsigned DIVISOR_WIDTH = 16,
  parameter int unsigned VALUE_WIDTH   = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PaddrW-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   code_bit_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [VALUE_WIDTH-1:0] decoded_value_o,
  output logic                   overflow_o
);

  localparam int unsigned DW = DIVISOR_WIDTH;

  logic [DW-1:0] divisor_q;
  logic          sign_mode_q;
  logic          cfg_write;
  beat_t         push;
  beat_t         head;
  logic          queue_full;
  logic          pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q   <= DW'(4);
      sign_mode_q <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        RegDivisor:  divisor_q   <= pwdata[DW-1:0];
        RegSignMode: sign_mode_q <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[2])
      RegDivisor:  prdata = 32'(divisor_q);
      RegSignMode: prdata = 32'(sign_mode_q);
      default:     prdata = '0;
    endcase
  end

  sgd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .code_bit_i   (code_bit_i),
    .push_o       (push),
    .queue_full_i (queue_full)
  );

  sgd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (queue_full),
    .head_o (head),
    .pop_i  (pop)
  );

  sgd_back #(
    .DIVISOR_WIDTH (DIVISOR_WIDTH),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .divisor_i       (divisor_q),
    .sign_mode_i     (sign_mode_q),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .decoded_value_o (decoded_value_o),
    .overflow_o      (overflow_o)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import sgd_pkg::*;
();

  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam logic [63:0] MagLimit      = 64'h0000_0000_7FFF_FFFF;

  typedef enum logic [1:0] {PhUnary, PhRemainder, PhExtra, PhSign} golomb_phase_e;

  typedef struct packed {
    logic [31:0] value;
    logic        overflow;
  } golomb_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              code_bit_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [31:0]       decoded_value_o;
  logic              overflow_o;

  // Mirror of the registers and of the codeword being decoded
  logic [15:0]   cfg_divisor;
  logic          cfg_sign_mode;
  golomb_phase_e dec_phase;
  logic [63:0]   mag_acc;
  logic [63:0]   rem_acc;
  int unsigned   rem_bits_left;
  logic          sat_seen;

  golomb_result_t expected_results[$];
  bit             code_stream[$];
  golomb_result_t want;

  int unsigned error_count     = 0;
  int unsigned bits_sent       = 0;
  int unsigned results_checked = 0;
  int unsigned idle_cycles     = 0;
  int unsigned hold_off_len    = 0;
  bit          idling_on       = 1'b1;

  signed_golomb_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .code_bit_i     (code_bit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .decoded_value_o(decoded_value_o),
    .overflow_o     (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Decoder mirror
  // ---------------------------------------------------------------------------

  // A divisor of zero behaves as one
  function automatic logic [63:0] eff_divisor();
    return (cfg_divisor == 16'd0) ? 64'd1 : {48'd0, cfg_divisor};
  endfunction

  function automatic int unsigned ceil_log2_of(logic [63:0] m);
    int unsigned b = 0;
    while (b < 40 && (64'd1 << b) < m) b++;
    return b;
  endfunction

  // Truncated-binary offset 2^b - m
  function automatic logic [63:0] trunc_offset();
    logic [63:0] m;
    m = eff_divisor();
    return (64'd1 << ceil_log2_of(m)) - m;
  endfunction

  // Saturating add into the magnitude
  function automatic void add_magnitude(logic [63:0] x);
    if (mag_acc > MagLimit || x > MagLimit - mag_acc) begin
      mag_acc  = MagLimit;
      sat_seen = 1'b1;
    end else begin
      mag_acc = mag_acc + x;
    end
  endfunction

  function automatic void clear_codeword();
    dec_phase     = PhUnary;
    mag_acc       = '0;
    rem_acc       = '0;
    rem_bits_left = 0;
    sat_seen      = 1'b0;
  endfunction

  function automatic void emit_value(logic [63:0] v);
    golomb_result_t res;
    res.value    = v[31:0];
    res.overflow = sat_seen;
    expected_results.push_back(res);
    clear_codeword();
  endfunction

  // Add the remainder, then sign the magnitude or wait for the sign bit
  function automatic void close_magnitude(logic [63:0] rem);
    add_magnitude(rem);
    if (mag_acc == 64'd0) emit_value(64'd0);
    else if (!cfg_sign_mode) dec_phase = PhSign;
    else if (mag_acc[0]) emit_value(64'd0 - ((mag_acc >> 1) + 64'd1));
    else emit_value(mag_acc >> 1);
  endfunction

  function automatic void settle_remainder();
    if (rem_acc >= trunc_offset()) dec_phase = PhExtra;
    else close_magnitude(rem_acc);
  endfunction

  // Advance the mirror by one accepted code bit
  function automatic void decode_bit(logic b);
    logic [63:0] m;
    logic [63:0] r;
    logic [63:0] u;
    m = eff_divisor();
    case (dec_phase)
      PhUnary: begin
        if (b) begin
          add_magnitude(m);
        end else if (m == 64'd1) begin
          close_magnitude(64'd0);
        end else begin
          rem_acc       = '0;
          rem_bits_left = ceil_log2_of(m) - 1;
          if (rem_bits_left == 0) settle_remainder();
          else dec_phase = PhRemainder;
        end
      end
      PhRemainder: begin
        rem_acc = (rem_acc << 1) | {63'd0, b};
        if (rem_bits_left > 0) rem_bits_left--;
        if (rem_bits_left == 0) settle_remainder();
      end
      PhExtra: begin
        u       = trunc_offset();
        r       = (rem_acc << 1) | {63'd0, b};
        r       = (r >= u) ? r - u : 64'd0;
        rem_acc = r;
        close_magnitude(r);
      end
      default: begin
        emit_value(b ? 64'd0 - mag_acc : mag_acc);
      end
    endcase
  endfunction

  // Append the codeword for x under the current settings
  function automatic void encode_value(longint x);
    logic [63:0] v;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] u;
    int unsigned b;
    m = eff_divisor();
    if (cfg_sign_mode) v = (x >= 0) ? 2 * x : -2 * x - 1;
    else v = (x < 0) ? -x : x;
    q = v / m;
    r = v % m;
    repeat (q) code_stream.push_back(1'b1);
    code_stream.push_back(1'b0);
    if (m > 64'd1) begin
      b = ceil_log2_of(m);
      u = (64'd1 << b) - m;
      if (r < u) begin
        for (int i = b - 2; i >= 0; i--) code_stream.push_back(r[i]);
      end else begin
        r = r + u;
        for (int i = b - 1; i >= 0; i--) code_stream.push_back(r[i]);
      end
    end
    if (!cfg_sign_mode && v != 64'd0) code_stream.push_back(x < 0);
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idling_on || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one code bit, hold it until taken, then update the mirror
  task automatic send_bit(input bit b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    code_bit_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_bit(b);
    bits_sent++;
  endtask

  task automatic send_stream();
    while (code_stream.size() != 0) send_bit(code_stream.pop_front());
  endtask

  task automatic send_codeword(input longint x);
    encode_value(x);
    send_stream();
  endtask

  // Feed zeros until the decoder is back at the start of a codeword
  task automatic realign();
    while (dec_phase != PhUnary || mag_acc != 64'd0) send_bit(1'b0);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline empty
  task automatic settle_all();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegDivisor) cfg_divisor = data[15:0];
    else cfg_sign_mode = data[0];
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic idx, input logic [31:0] exp_data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== exp_data) begin
      $display("%0t: register %0d readback: expected %h, actual %h",
               $time, idx, exp_data, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write both registers, then read them back
  task automatic configure(input logic [31:0] div_word, input logic [31:0] mode_word);
    write_reg(RegDivisor, div_word);
    write_reg(RegSignMode, mode_word);
    check_reg(RegDivisor, {16'd0, cfg_divisor});
    check_reg(RegSignMode, {31'd0, cfg_sign_mode});
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // Stall the output at random, or hold it off for a requested stretch
  initial begin
    int unsigned span;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_off_len) @(posedge clk_i);
        hold_off_len = 0;
      end else begin
        span = pick_gap();
        out_stall_i <= (span != 0);
        repeat ((span != 0) ? span : 1) @(posedge clk_i);
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, actual %0d ovf %0b",
                 $time, $signed(decoded_value_o), overflow_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (decoded_value_o !== want.value) begin
          $display("%0t: decoded_value: expected %0d, actual %0d",
                   $time, $signed(want.value), $signed(decoded_value_o));
          error_count++;
        end
        if (overflow_o !== want.overflow) begin
          $display("%0t: overflow: expected %0b, actual %0b",
                   $time, want.overflow, overflow_o);
          error_count++;
        end
      end
    end
  end

  // Abort when no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, idle_cycles, expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, then a few codewords with divisor four
  task automatic test_register_defaults();
    check_reg(RegDivisor, 32'd4);
    check_reg(RegSignMode, 32'd0);
    send_codeword(0);
    send_codeword(1);
    send_codeword(-1);
    send_codeword(5);
    send_codeword(-7);
    settle_all();
  endtask

  // Divisor one reads no remainder bits; divisor zero acts as one
  task automatic test_divisor_one();
    configure(32'hABCD_0001, 32'h0000_0000);
    send_codeword(0);
    send_codeword(3);
    send_codeword(-2);
    settle_all();
    configure(32'hFFFF_0000, 32'hFFFF_FFFE);
    send_codeword(2);
    send_codeword(-1);
    settle_all();
    configure(32'h0000_0000, 32'h0000_0001);
    send_codeword(-3);
    send_codeword(4);
    send_codeword(0);
    settle_all();
  endtask

  // Widest divisor and powers of two in both sign modes, and a small odd one
  task automatic test_wide_divisor();
    configure(32'd65535, 32'd1);
    send_codeword(0);
    send_codeword(65534);
    send_codeword(-65535);
    settle_all();
    configure(32'd65535, 32'd0);
    send_codeword(65535);
    send_codeword(-1);
    settle_all();
    configure(32'h0000_8000, 32'd0);
    send_codeword(40000);
    settle_all();
    configure(32'd3, 32'd0);
    send_codeword(0);
    send_codeword(1);
    send_codeword(-2);
    send_codeword(2);
    settle_all();
    configure(32'd2, 32'd1);
    send_codeword(1);
    send_codeword(-1);
    settle_all();
  endtask

  // Registers rewritten while a codeword is half decoded
  task automatic test_midword_changes();
    // remainder phase continues under a new divisor
    configure(32'd5, 32'd0);
    send_bit(1'b0);
    send_bit(1'b1);
    settle_all();
    configure(32'd2, 32'd0);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    settle_all();
    // extra-bit remainder falls below the new offset and clamps to zero
    configure(32'd3, 32'd0);
    send_bit(1'b0);
    send_bit(1'b1);
    settle_all();
    configure(32'd33000, 32'd0);
    send_bit(1'b1);
    settle_all();
    // sign rule switched in the middle of the unary part
    configure(32'd4, 32'd0);
    send_bit(1'b1);
    send_bit(1'b1);
    settle_all();
    configure(32'd4, 32'd1);
    send_codeword(3);
    realign();
    settle_all();
  endtask

  // Hold the output off while one-bit codewords keep coming, then drain
  task automatic test_backpressure();
    configure(32'd1, 32'd0);
    idling_on    = 1'b0;
    hold_off_len = 300;
    repeat (48) send_bit(1'b0);
    settle_all();
    idling_on = 1'b1;
  endtask

  // Random settings, mostly well-formed codewords with some stray bits
  task automatic test_random_streams();
    logic [15:0] div;
    logic [31:0] word;
    int unsigned start_bits;
    int unsigned roll;
    int unsigned bound;
    longint      x;
    for (int p = 0; p < 7; p++) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) div = 16'($urandom_range(0, 1));
      else if (roll < 35) div = 16'd1 << $urandom_range(1, 15);
      else if (roll < 85) div = 16'($urandom_range(2, 20));
      else div = 16'($urandom_range(21, 65535));
      word       = $urandom();
      word[15:0] = div;
      configure(word, $urandom());
      idling_on  = (p != 3);
      start_bits = bits_sent;
      while (bits_sent - start_bits < 60) begin
        if ($urandom_range(0, 99) < 88) begin
          bound = 32'(eff_divisor());
          bound = (bound < 64) ? 3 * bound + 3 : 2 * bound;
          x = longint'($urandom_range(0, bound));
          if ($urandom_range(0, 1) != 0) x = -x;
          send_codeword(x);
        end else begin
          repeat ($urandom_range(1, 6)) code_stream.push_back($urandom_range(0, 1) != 0);
          send_stream();
          if ($urandom_range(0, 1) != 0) realign();
        end
      end
      settle_all();
    end
    idling_on = 1'b1;
  endtask

  initial begin
    rst_ni     <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid_i <= 1'b0;
    code_bit_i <= 1'b0;
    cfg_divisor   = 16'd4;
    cfg_sign_mode = 1'b0;
    clear_codeword();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_defaults();
    test_divisor_one();
    test_wide_divisor();
    test_midword_changes();
    test_backpressure();
    test_random_streams();

    $display("Run summary: %0d code bits sent, %0d decoded values compared",
             bits_sent, results_checked);
    $display("Divisors 0 to 65535, both sign rules, mid-codeword rewrites, backpressure");
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sgd_pkg.sv
hw/rtl/sgd_front.sv
hw/rtl/sgd_queue.sv
hw/rtl/sgd_back.sv
hw/rtl/signed_golomb_decoder.sv
dv/tb_top.sv
